/* hdl/pli_pkg.sv */
// pli_pkg: shared types and constants of the leaky-integral pid controller
// used by every design module of the block, no dependencies
`timescale 1ns / 1ps

package pli_pkg;

  localparam int ERR_W   = 16;
  localparam int GAIN_W  = 16;
  localparam int INTEG_W = 20;
  localparam int DERIV_W = ERR_W + 1;
  localparam int PROD_P_W = GAIN_W + ERR_W;
  localparam int PROD_I_W = GAIN_W + INTEG_W;
  localparam int PROD_D_W = GAIN_W + DERIV_W;
  localparam int SUM_W   = PROD_I_W + 2;
  localparam int FRAC_W  = 8;
  localparam int OUT_W   = 16;
  localparam int ADDR_W  = 4;

  typedef enum logic [1:0] {
    REG_GAIN_PROP  = 2'd0,
    REG_GAIN_INTEG = 2'd1,
    REG_GAIN_DERIV = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic signed [GAIN_W-1:0] prop;
    logic signed [GAIN_W-1:0] integ;
    logic signed [GAIN_W-1:0] deriv;
  } gains_t;

endpackage

/* hdl/pli_cfg_regs.sv */
// pli_cfg_regs: apb gain registers of the pid controller
// depends on pli_pkg
`timescale 1ns / 1ps

module pli_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pli_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output pli_pkg::gains_t            gains_o
);
  import pli_pkg::*;

  gains_t   gains_q, gains_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx   = reg_idx_e'(paddr[3:2]);
  assign wr_en = psel && penable && pwrite;

  always_comb begin
    gains_d = gains_q;
    if (wr_en) begin
      unique case (idx)
        REG_GAIN_PROP:  gains_d.prop  = pwdata[GAIN_W-1:0];
        REG_GAIN_INTEG: gains_d.integ = pwdata[GAIN_W-1:0];
        REG_GAIN_DERIV: gains_d.deriv = pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_GAIN_PROP:  prdata = {{(32-GAIN_W){gains_q.prop[GAIN_W-1]}}, gains_q.prop};
      REG_GAIN_INTEG: prdata = {{(32-GAIN_W){gains_q.integ[GAIN_W-1]}}, gains_q.integ};
      REG_GAIN_DERIV: prdata = {{(32-GAIN_W){gains_q.deriv[GAIN_W-1]}}, gains_q.deriv};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q <= '0;
    end else begin
      gains_q <= gains_d;
    end
  end

  assign gains_o = gains_q;

endmodule

/* hdl/pli_state_stage.sv */
// pli_state_stage: leaky integral and derivative update, first pipeline stage
// depends on pli_pkg
`timescale 1ns / 1ps

module pli_state_stage (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               load_i,
  input  logic signed [pli_pkg::ERR_W-1:0]   error_i,
  output logic signed [pli_pkg::ERR_W-1:0]   err_o,
  output logic signed [pli_pkg::INTEG_W-1:0] integ_o,
  output logic signed [pli_pkg::DERIV_W-1:0] deriv_o
);
  import pli_pkg::*;

  localparam int TRI_W = INTEG_W + 2;

  logic signed [INTEG_W-1:0] integral_q, integral_d;
  logic signed [ERR_W-1:0]   prev_error_q;
  logic signed [ERR_W-1:0]   err_q;
  logic signed [DERIV_W-1:0] deriv_q, deriv_d;
  logic signed [TRI_W-1:0]   tri_val, biased;
  logic signed [INTEG_W-1:0] leak;
  logic signed [INTEG_W:0]   integ_sum;

  always_comb begin
    tri_val = {{2{integral_q[INTEG_W-1]}}, integral_q}
            + {integral_q[INTEG_W-1], integral_q, 1'b0};
    // round toward zero for negative values
    biased  = tri_val + (integral_q[INTEG_W-1] ? TRI_W'(3) : TRI_W'(0));
    leak    = biased[TRI_W-1:2];
    integ_sum = {leak[INTEG_W-1], leak}
              + {{(INTEG_W+1-ERR_W){error_i[ERR_W-1]}}, error_i};
    if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
      integral_d = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                      : {1'b0, {(INTEG_W-1){1'b1}}};
    end else begin
      integral_d = integ_sum[INTEG_W-1:0];
    end
    deriv_d = {error_i[ERR_W-1], error_i} - {prev_error_q[ERR_W-1], prev_error_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integral_q   <= '0;
      prev_error_q <= '0;
    end else if (load_i) begin
      integral_q   <= integral_d;
      prev_error_q <= error_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      err_q   <= error_i;
      deriv_q <= deriv_d;
    end
  end

  assign err_o   = err_q;
  assign integ_o = integral_q;
  assign deriv_o = deriv_q;

endmodule

/* hdl/pli_mac_stage.sv */
// pli_mac_stage: gain products, sum, scaling and saturation
// depends on pli_pkg
`timescale 1ns / 1ps

module pli_mac_stage (
  input  logic                               clk_i,
  input  logic                               load_prod_i,
  input  logic                               load_out_i,
  input  pli_pkg::gains_t                    gains_i,
  input  logic signed [pli_pkg::ERR_W-1:0]   err_i,
  input  logic signed [pli_pkg::INTEG_W-1:0] integ_i,
  input  logic signed [pli_pkg::DERIV_W-1:0] deriv_i,
  output logic signed [pli_pkg::OUT_W-1:0]   drive_o
);
  import pli_pkg::*;

  localparam int SHR_W = SUM_W - FRAC_W;

  logic signed [PROD_P_W-1:0] prod_p_q;
  logic signed [PROD_I_W-1:0] prod_i_q;
  logic signed [PROD_D_W-1:0] prod_d_q;
  logic signed [SUM_W-1:0]    sum;
  logic signed [SHR_W-1:0]    shr;
  logic signed [OUT_W-1:0]    drive_d, drive_q;

  always_ff @(posedge clk_i) begin
    if (load_prod_i) begin
      prod_p_q <= gains_i.prop  * err_i;
      prod_i_q <= gains_i.integ * integ_i;
      prod_d_q <= gains_i.deriv * deriv_i;
    end
  end

  always_comb begin
    sum = {{(SUM_W-PROD_P_W){prod_p_q[PROD_P_W-1]}}, prod_p_q}
        + {{(SUM_W-PROD_I_W){prod_i_q[PROD_I_W-1]}}, prod_i_q}
        + {{(SUM_W-PROD_D_W){prod_d_q[PROD_D_W-1]}}, prod_d_q};
    shr = sum[SUM_W-1:FRAC_W];
    if (shr[SHR_W-1:OUT_W-1] == '0 || shr[SHR_W-1:OUT_W-1] == '1) begin
      drive_d = shr[OUT_W-1:0];
    end else if (shr[SHR_W-1]) begin
      drive_d = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      drive_d = {1'b0, {(OUT_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out_i) begin
      drive_q <= drive_d;
    end
  end

  assign drive_o = drive_q;

endmodule

/* hdl/pid_leaky_integral.sv */
// pid_leaky_integral: top level of the leaky-integral pid controller
// depends on pli_pkg, pli_cfg_regs, pli_state_stage, pli_mac_stage
`timescale 1ns / 1ps

// One error sample is taken per clock cycle while in_stall_o is low and gives
// one drive value via the integral/derivative, product, and sum and saturation
// stages. The integral update loops on the state register alone, so the
// sustained rate is one sample per cycle. Each stage fills independently, so the
// block keeps taking samples while a result waits; in_stall_o rises only when
// all three stages hold data and out_stall_i is high. The user must write gains
// over the apb port at byte addresses 0, 4 and 8 only while the pipe is empty;
// this is not enforced. Integral and previous error survive gain changes.
module pid_leaky_integral (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pli_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [15:0]         error_in_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [15:0]         drive_out_o
);
  import pli_pkg::*;

  gains_t                    gains;
  logic signed [ERR_W-1:0]   s1_err;
  logic signed [INTEG_W-1:0] s1_integ;
  logic signed [DERIV_W-1:0] s1_deriv;
  logic                      v1_q, v2_q, v3_q;
  logic                      en1, en2, en3;

  assign pready = 1'b1;

  assign en3 = !v3_q || !out_stall_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_stall_o  = !en1;
  assign out_valid_o = v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= in_valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  pli_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .gains_o (gains)
  );

  pli_state_stage u_state (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (in_valid_i && en1),
    .error_i (error_in_i),
    .err_o   (s1_err),
    .integ_o (s1_integ),
    .deriv_o (s1_deriv)
  );

  pli_mac_stage u_mac (
    .clk_i       (clk_i),
    .load_prod_i (v1_q && en2),
    .load_out_i  (v2_q && en3),
    .gains_i     (gains),
    .err_i       (s1_err),
    .integ_i     (s1_integ),
    .deriv_i     (s1_deriv),
    .drive_o     (drive_out_o)
  );

endmodule

/* hdl/pli_checker.sv */
// pli_checker: port-level assertions of the pid controller, bound to the top
// depends on pid_leaky_integral ports only
`timescale 1ns / 1ps

module pli_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] drive_out_o
);

  logic [2:0] inflight_q;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else if (in_xfer && !out_xfer) begin
      inflight_q <= inflight_q + 3'd1;
    end else if (out_xfer && !in_xfer) begin
      inflight_q <= inflight_q - 3'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(drive_out_o))
    else $error("stalled result changed");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with room in the pipe");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= 3'd3)
    else $error("more transfers in flight than pipe stages");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> inflight_q != 3'd0)
    else $error("result without a pending input transfer");

endmodule

bind pid_leaky_integral pli_checker u_pli_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .drive_out_o (drive_out_o)
);
